/* rtl/ohlc_pkg.sv */
package ohlc_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int COUNT_WIDTH = 32;
	localparam int TS_WIDTH = 32;
	localparam int TS_IDX_W = $clog2(TS_WIDTH);
	localparam int LEN_WIDTH = 20;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam logic [LEN_WIDTH-1:0] INTERVAL_RESET = LEN_WIDTH'(900);

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [TS_WIDTH-1:0] ts_t;
	typedef logic [LEN_WIDTH-1:0] len_t;

	typedef struct packed {
		ts_t    timestamp;
		value_t open_price;
		value_t high_price;
		value_t low_price;
		value_t close_price;
		value_t base_volume;
		value_t quote_volume;
		count_t trade_count;
		value_t buy_base_volume;
		value_t sell_base_volume;
		logic   end_of_series;
	} base_t;

	typedef struct packed {
		ts_t   bucket;
		base_t base;
	} entry_t;

	typedef struct packed {
		ts_t    bucket;
		value_t open_price;
		value_t high_price;
		value_t low_price;
		value_t close_price;
		value_t base_volume;
		value_t quote_volume;
		count_t trade_count;
		value_t buy_volume;
		value_t sell_volume;
	} candle_t;

endpackage

/* rtl/ohlc_if.sv */
interface ohlc_base_if;
	logic                  valid;
	logic                  ready;
	ohlc_pkg::ts_t         timestamp;
	ohlc_pkg::value_t      open_price;
	ohlc_pkg::value_t      high_price;
	ohlc_pkg::value_t      low_price;
	ohlc_pkg::value_t      close_price;
	ohlc_pkg::value_t      base_volume;
	ohlc_pkg::value_t      quote_volume;
	ohlc_pkg::count_t      trade_count;
	ohlc_pkg::value_t      buy_base_volume;
	ohlc_pkg::value_t      sell_base_volume;
	logic                  end_of_series;

	modport source (
		output valid, timestamp, open_price, high_price, low_price, close_price,
		       base_volume, quote_volume, trade_count, buy_base_volume,
		       sell_base_volume, end_of_series,
		input  ready
	);
	modport sink (
		input  valid, timestamp, open_price, high_price, low_price, close_price,
		       base_volume, quote_volume, trade_count, buy_base_volume,
		       sell_base_volume, end_of_series,
		output ready
	);
endinterface

interface ohlc_agg_if;
	logic                  valid;
	logic                  ready;
	ohlc_pkg::ts_t         bucket_start;
	ohlc_pkg::value_t      agg_open;
	ohlc_pkg::value_t      agg_high;
	ohlc_pkg::value_t      agg_low;
	ohlc_pkg::value_t      agg_close;
	ohlc_pkg::value_t      agg_base_volume;
	ohlc_pkg::value_t      agg_quote_volume;
	ohlc_pkg::count_t      agg_trade_count;
	ohlc_pkg::value_t      agg_buy_volume;
	ohlc_pkg::value_t      agg_sell_volume;
	logic                  run_last;

	modport source (
		output valid, bucket_start, agg_open, agg_high, agg_low, agg_close,
		       agg_base_volume, agg_quote_volume, agg_trade_count, agg_buy_volume,
		       agg_sell_volume, run_last,
		input  ready
	);
	modport sink (
		input  valid, bucket_start, agg_open, agg_high, agg_low, agg_close,
		       agg_base_volume, agg_quote_volume, agg_trade_count, agg_buy_volume,
		       agg_sell_volume, run_last,
		output ready
	);
endinterface

interface ohlc_cfg_if;
	logic                  valid;
	logic                  ready;
	ohlc_pkg::len_t        interval_seconds;

	modport source (output valid, interval_seconds, input ready);
	modport sink (input valid, interval_seconds, output ready);
endinterface

/* rtl/ohlc_front.sv */
module ohlc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	ohlc_base_if.sink            base,
	input  ohlc_pkg::len_t       interval,
	output logic                 push_valid,
	input  logic                 push_ready,
	output ohlc_pkg::entry_t     push_data
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_PUSH = 3'b100
	} front_state_t;

	front_state_t                      state_q;
	logic [ohlc_pkg::TS_IDX_W-1:0]     cnt_q;
	logic [ohlc_pkg::LEN_WIDTH-1:0]    rem_q;
	ohlc_pkg::len_t                    len_q;
	ohlc_pkg::base_t                   item_q;
	logic [ohlc_pkg::LEN_WIDTH:0]      rem_shift;
	logic [ohlc_pkg::LEN_WIDTH:0]      rem_next;
	logic                              accept;

	assign base.ready = (state_q == S_IDLE);
	assign accept = base.valid && base.ready;

	assign rem_shift = {rem_q, item_q.timestamp[cnt_q]};
	assign rem_next = (rem_shift >= {1'b0, len_q}) ? rem_shift - {1'b0, len_q} : rem_shift;

	assign push_valid = (state_q == S_PUSH);
	assign push_data.base = item_q;
	assign push_data.bucket = item_q.timestamp - ohlc_pkg::TS_WIDTH'(rem_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0) state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (push_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.timestamp <= base.timestamp;
			item_q.open_price <= base.open_price;
			item_q.high_price <= base.high_price;
			item_q.low_price <= base.low_price;
			item_q.close_price <= base.close_price;
			item_q.base_volume <= base.base_volume;
			item_q.quote_volume <= base.quote_volume;
			item_q.trade_count <= base.trade_count;
			item_q.buy_base_volume <= base.buy_base_volume;
			item_q.sell_base_volume <= base.sell_base_volume;
			item_q.end_of_series <= base.end_of_series;
			rem_q <= '0;
			cnt_q <= ohlc_pkg::TS_IDX_W'(ohlc_pkg::TS_WIDTH - 1);
			len_q <= (interval == '0) ? ohlc_pkg::LEN_WIDTH'(1) : interval;
		end else if (state_q == S_DIV) begin
			rem_q <= rem_next[ohlc_pkg::LEN_WIDTH-1:0];
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* rtl/ohlc_fifo.sv */
module ohlc_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  ohlc_pkg::entry_t     push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output ohlc_pkg::entry_t     pop_data
);

	ohlc_pkg::entry_t                  slot_q [ohlc_pkg::FIFO_DEPTH];
	logic [ohlc_pkg::FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [ohlc_pkg::FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [ohlc_pkg::FIFO_PTR_W:0]     count_q;
	logic                              do_push;
	logic                              do_pop;

	assign push_ready = (count_q != (ohlc_pkg::FIFO_PTR_W + 1)'(ohlc_pkg::FIFO_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = slot_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	function automatic logic [ohlc_pkg::FIFO_PTR_W-1:0] ptr_inc(
		input logic [ohlc_pkg::FIFO_PTR_W-1:0] p
	);
		if (p == ohlc_pkg::FIFO_PTR_W'(ohlc_pkg::FIFO_DEPTH - 1)) return '0;
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

/* rtl/ohlc_back.sv */
module ohlc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  ohlc_pkg::entry_t     pop_data,
	ohlc_agg_if.source           agg
);

	typedef enum logic [1:0] {
		B_MERGE = 2'b01,
		B_FLUSH = 2'b10
	} back_state_t;

	back_state_t          state_q;
	ohlc_pkg::candle_t    held_q;
	logic                 held_valid_q;
	ohlc_pkg::candle_t    out_q;
	logic                 out_last_q;
	logic                 out_valid_q;
	ohlc_pkg::candle_t    merged;
	ohlc_pkg::base_t      b;
	logic                 hit;
	logic                 out_free;
	logic                 take;
	logic                 emit_old;
	logic                 emit_merged;
	logic                 flush;
	logic                 out_load;

	assign b = pop_data.base;
	assign hit = held_valid_q && (pop_data.bucket == held_q.bucket);
	assign out_free = !out_valid_q || agg.ready;
	assign pop_ready = (state_q == B_MERGE) && out_free;
	assign take = pop_valid && pop_ready;
	assign emit_old = take && held_valid_q && !hit;
	assign emit_merged = take && !emit_old && b.end_of_series;
	assign flush = (state_q == B_FLUSH) && out_free;
	assign out_load = emit_old || emit_merged || flush;

	always_comb begin
		if (hit) begin
			merged.bucket = held_q.bucket;
			merged.open_price = held_q.open_price;
			merged.high_price = (b.high_price > held_q.high_price) ? b.high_price
				: held_q.high_price;
			merged.low_price = (b.low_price < held_q.low_price) ? b.low_price
				: held_q.low_price;
			merged.close_price = b.close_price;
			merged.base_volume = held_q.base_volume + b.base_volume;
			merged.quote_volume = held_q.quote_volume + b.quote_volume;
			merged.trade_count = held_q.trade_count + b.trade_count;
			merged.buy_volume = held_q.buy_volume + b.buy_base_volume;
			merged.sell_volume = held_q.sell_volume + b.sell_base_volume;
		end else begin
			merged.bucket = pop_data.bucket;
			merged.open_price = b.open_price;
			merged.high_price = b.high_price;
			merged.low_price = b.low_price;
			merged.close_price = b.close_price;
			merged.base_volume = b.base_volume;
			merged.quote_volume = b.quote_volume;
			merged.trade_count = b.trade_count;
			merged.buy_volume = b.buy_base_volume;
			merged.sell_volume = b.sell_base_volume;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_MERGE;
			held_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (agg.ready) out_valid_q <= 1'b0;

			if (take) held_valid_q <= !(b.end_of_series && !emit_old);
			else if (flush) held_valid_q <= 1'b0;

			unique case (state_q)
				B_MERGE: begin
					if (emit_old && b.end_of_series) state_q <= B_FLUSH;
				end
				B_FLUSH: begin
					if (flush) state_q <= B_MERGE;
				end
				default: state_q <= B_MERGE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) held_q <= merged;
		if (emit_old || flush) out_q <= held_q;
		else if (emit_merged) out_q <= merged;
		if (out_load) out_last_q <= emit_old ? !b.end_of_series : 1'b1;
	end

	assign agg.valid = out_valid_q;
	assign agg.bucket_start = out_q.bucket;
	assign agg.agg_open = out_q.open_price;
	assign agg.agg_high = out_q.high_price;
	assign agg.agg_low = out_q.low_price;
	assign agg.agg_close = out_q.close_price;
	assign agg.agg_base_volume = out_q.base_volume;
	assign agg.agg_quote_volume = out_q.quote_volume;
	assign agg.agg_trade_count = out_q.trade_count;
	assign agg.agg_buy_volume = out_q.buy_volume;
	assign agg.agg_sell_volume = out_q.sell_volume;
	assign agg.run_last = out_last_q;

endmodule

/* rtl/ohlc_candle_aggregator.sv */
// Merges time-ordered base candles into candles of interval_seconds length
// (0 counts as 1), each keyed by its timestamp rounded down to a multiple of
// the interval. A candle in a new interval releases the held one; an
// end_of_series item releases what is held after merging, and run_last marks
// the last result an item causes. The front part takes a new item only once
// the last is handed off: it accepts the item, finds the interval start with
// a remainder loop that retires one timestamp bit per cycle, and hands it to
// a two-entry queue. The merge stage behind it takes one item a cycle while
// its output is free, and pauses to flush when an end_of_series item also
// closes a different interval. Results sit in an output register, so the
// input keeps flowing while the result side stalls, until the queue fills.
module ohlc_candle_aggregator (
	input  logic         clk,
	input  logic         arst_n,
	ohlc_base_if.sink    base,
	ohlc_agg_if.source   agg,
	ohlc_cfg_if.sink     cfg
);

	ohlc_pkg::len_t     interval_q;
	logic               push_valid;
	logic               push_ready;
	ohlc_pkg::entry_t   push_data;
	logic               pop_valid;
	logic               pop_ready;
	ohlc_pkg::entry_t   pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= ohlc_pkg::INTERVAL_RESET;
		end else if (cfg.valid && cfg.ready) begin
			interval_q <= cfg.interval_seconds;
		end
	end

	ohlc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.base       (base),
		.interval   (interval_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	ohlc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	ohlc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.agg       (agg)
	);

endmodule

/* dv/ohlc_candle_aggregator_tb.sv */
`timescale 1ns / 100ps

module ohlc_candle_aggregator_tb;

	typedef struct packed {
		ohlc_pkg::candle_t candle;
		logic              run_last;
	} agg_result_t;

	typedef struct {
		logic            is_cfg;
		ohlc_pkg::len_t  interval;
		ohlc_pkg::base_t item;
		logic            typed;
		ohlc_pkg::ts_t   want_bucket;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ohlc_base_if base_ch ();
	ohlc_agg_if  agg_ch ();
	ohlc_cfg_if  cfg_ch ();

	ohlc_candle_aggregator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.base   (base_ch),
		.agg    (agg_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// model of the block
	ohlc_pkg::len_t    interval_cfg = ohlc_pkg::INTERVAL_RESET;
	bit                held_valid = 1'b0;
	ohlc_pkg::candle_t held_candle = '0;
	agg_result_t       pending_candles[$];
	plan_row_t         plan[$];

	bit feed_idle = 1'b1;
	bit sink_stall = 1'b1;
	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int cfg_writes = 0;

	function automatic void add_row(plan_row_t r);
		plan.insert(plan.size(), r);
	endfunction

	function automatic void expect_candle(ohlc_pkg::candle_t cd, logic last);
		pending_candles.insert(pending_candles.size(), '{candle: cd, run_last: last});
	endfunction

	function automatic int pick_gap(bit enabled);
		int r;
		if (!enabled) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic ohlc_pkg::value_t rand_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return ohlc_pkg::value_t'($urandom_range(0, 1000));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic ohlc_pkg::base_t rand_candle();
		ohlc_pkg::base_t c;
		c.timestamp = $urandom;
		c.open_price = rand_value();
		c.high_price = rand_value();
		c.low_price = rand_value();
		c.close_price = rand_value();
		c.base_volume = rand_value();
		c.quote_volume = rand_value();
		c.trade_count = ohlc_pkg::count_t'(rand_value());
		if ($urandom_range(0, 3) == 0) begin
			c.trade_count = $urandom;
		end
		c.buy_base_volume = rand_value();
		c.sell_base_volume = rand_value();
		c.end_of_series = 1'($urandom_range(0, 1));
		return c;
	endfunction

	function automatic void merge_candle(ohlc_pkg::base_t c);
		ohlc_pkg::ts_t span;
		ohlc_pkg::ts_t bucket;
		span = (interval_cfg == '0) ? ohlc_pkg::ts_t'(1) : ohlc_pkg::ts_t'(interval_cfg);
		bucket = (c.timestamp / span) * span;
		if (held_valid && bucket == held_candle.bucket) begin
			if (c.high_price > held_candle.high_price) begin
				held_candle.high_price = c.high_price;
			end
			if (c.low_price < held_candle.low_price) begin
				held_candle.low_price = c.low_price;
			end
			held_candle.close_price = c.close_price;
			held_candle.base_volume += c.base_volume;
			held_candle.quote_volume += c.quote_volume;
			held_candle.trade_count += c.trade_count;
			held_candle.buy_volume += c.buy_base_volume;
			held_candle.sell_volume += c.sell_base_volume;
		end else begin
			if (held_valid) begin
				expect_candle(held_candle, !c.end_of_series);
			end
			held_valid = 1'b1;
			held_candle = '{bucket, c.open_price, c.high_price, c.low_price, c.close_price,
				c.base_volume, c.quote_volume, c.trade_count, c.buy_base_volume,
				c.sell_base_volume};
		end
		if (c.end_of_series) begin
			expect_candle(held_candle, 1'b1);
			held_valid = 1'b0;
		end
	endfunction

	function automatic plan_row_t cfg_row(ohlc_pkg::len_t v);
		plan_row_t r;
		r.is_cfg = 1'b1;
		r.interval = v;
		r.item = '0;
		r.typed = 1'b0;
		r.want_bucket = '0;
		return r;
	endfunction

	function automatic plan_row_t item_row(ohlc_pkg::ts_t ts, ohlc_pkg::value_t o,
			ohlc_pkg::value_t h, ohlc_pkg::value_t l, ohlc_pkg::value_t cl,
			ohlc_pkg::value_t v, ohlc_pkg::count_t tc, logic eos);
		plan_row_t r;
		r.is_cfg = 1'b0;
		r.interval = '0;
		r.item = '{ts, o, h, l, cl, v, ~v, tc, v >> 1, v + 1, eos};
		r.typed = 1'b0;
		r.want_bucket = '0;
		return r;
	endfunction

	function automatic plan_row_t typed_row(plan_row_t r, ohlc_pkg::ts_t b);
		plan_row_t t;
		t = r;
		t.typed = 1'b1;
		t.want_bucket = b;
		return t;
	endfunction

	task automatic send_candle(ohlc_pkg::base_t c);
		int gap;
		gap = pick_gap(feed_idle);
		if (gap > 0) begin
			base_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		base_ch.valid <= 1'b1;
		base_ch.timestamp <= c.timestamp;
		base_ch.open_price <= c.open_price;
		base_ch.high_price <= c.high_price;
		base_ch.low_price <= c.low_price;
		base_ch.close_price <= c.close_price;
		base_ch.base_volume <= c.base_volume;
		base_ch.quote_volume <= c.quote_volume;
		base_ch.trade_count <= c.trade_count;
		base_ch.buy_base_volume <= c.buy_base_volume;
		base_ch.sell_base_volume <= c.sell_base_volume;
		base_ch.end_of_series <= c.end_of_series;
		do @(posedge clk); while (!base_ch.ready);
		merge_candle(c);
		items_sent++;
	endtask

	// hold the feed until every pending candle is out
	task automatic drain_pending(int settle_cycles);
		base_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_candles.size() > 0);
		repeat (settle_cycles) @(posedge clk);
	endtask

	task automatic write_interval(ohlc_pkg::len_t v);
		drain_pending(200);
		cfg_ch.valid <= 1'b1;
		cfg_ch.interval_seconds <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		interval_cfg = v;
		cfg_writes++;
	endtask

	task automatic run_phase(ohlc_pkg::len_t iv, int n_items);
		int sent;
		int span;
		int series_len;
		ohlc_pkg::ts_t ts;
		ohlc_pkg::base_t c;
		sent = 0;
		span = (iv == '0) ? 1 : int'(iv);
		while (sent < n_items) begin
			if (sent >= n_items / 2 && sent < n_items / 2 + 1) begin
				drain_pending(0);
			end
			if ($urandom_range(0, 9) == 0) begin
				send_candle(rand_candle());
				sent++;
				continue;
			end
			case ($urandom_range(0, 3))
				0: ts = $urandom_range(0, 3 * span);
				1: ts = 32'hFFFF_FFFF - $urandom_range(0, 3 * span);
				default: ts = $urandom;
			endcase
			series_len = $urandom_range(1, 24);
			for (int k = 0; k < series_len; k++) begin
				c = rand_candle();
				c.timestamp = ts;
				c.end_of_series = (k == series_len - 1) && ($urandom_range(0, 4) != 0);
				send_candle(c);
				sent++;
				case ($urandom_range(0, 19))
					0: ts -= $urandom_range(1, span);
					1, 2: ts += $urandom_range(span, 4 * span);
					default: ts += $urandom_range(0, span / 3);
				endcase
			end
		end
	endtask

	// result side
	initial begin : sink_side
		int gap;
		agg_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			gap = pick_gap(sink_stall);
			if (gap > 0) begin
				agg_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			agg_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			if (mismatches < 10) begin
				$display("%0t: %s expected %h got %h", $realtime, name, want, got);
			end
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : agg_check
		agg_result_t want;
		if (arst_n && agg_ch.valid && agg_ch.ready) begin
			results_seen++;
			if (pending_candles.size() == 0) begin
				if (mismatches < 10) begin
					$display("%0t: aggregated candle %h with nothing pending",
						$realtime, agg_ch.bucket_start);
				end
				mismatches++;
			end else begin
				want = pending_candles.pop_front();
				check_field("bucket_start", 64'(want.candle.bucket),
					64'(agg_ch.bucket_start));
				check_field("agg_open", want.candle.open_price, agg_ch.agg_open);
				check_field("agg_high", want.candle.high_price, agg_ch.agg_high);
				check_field("agg_low", want.candle.low_price, agg_ch.agg_low);
				check_field("agg_close", want.candle.close_price, agg_ch.agg_close);
				check_field("agg_base_volume", want.candle.base_volume,
					agg_ch.agg_base_volume);
				check_field("agg_quote_volume", want.candle.quote_volume,
					agg_ch.agg_quote_volume);
				check_field("agg_trade_count", 64'(want.candle.trade_count),
					64'(agg_ch.agg_trade_count));
				check_field("agg_buy_volume", want.candle.buy_volume, agg_ch.agg_buy_volume);
				check_field("agg_sell_volume", want.candle.sell_volume,
					agg_ch.agg_sell_volume);
				check_field("run_last", 64'(want.run_last), 64'(agg_ch.run_last));
			end
		end
	end

	initial begin : stimulus
		ohlc_pkg::len_t phase_interval[8];
		ohlc_pkg::base_t c;
		arst_n <= 1'b0;
		base_ch.valid <= 1'b0;
		base_ch.timestamp <= '0;
		base_ch.open_price <= '0;
		base_ch.high_price <= '0;
		base_ch.low_price <= '0;
		base_ch.close_price <= '0;
		base_ch.base_volume <= '0;
		base_ch.quote_volume <= '0;
		base_ch.trade_count <= '0;
		base_ch.buy_base_volume <= '0;
		base_ch.sell_base_volume <= '0;
		base_ch.end_of_series <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.interval_seconds <= ohlc_pkg::INTERVAL_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		add_row(typed_row(item_row(32'd1799, 100, 120, 90, 110, 5, 3, 1'b1), 32'd900));
		add_row(typed_row(item_row('1, '1, '1, '1, '1, '1, '1, 1'b1), 32'd4294966500));
		add_row(typed_row(item_row('0, 0, 0, 0, 0, 0, 0, 1'b1), 32'd0));
		add_row(item_row(32'd1800, 50, 60, 40, 55, 64'hFFFF_FFFF_FFFF_FFF0,
			32'hFFFF_FFF0, 1'b0));
		add_row(item_row(32'd2000, 51, 70, 45, 52, 32, 32, 1'b0));
		add_row(item_row(32'd2699, 53, 65, 30, 54, 1, 1, 1'b0));
		add_row(item_row(32'd2700, 54, 54, 54, 54, 7, 7, 1'b0));
		add_row(item_row(32'd2100, 9, 9, 9, 9, 1, 1, 1'b0));
		add_row(item_row(32'd9000, 8, 8, 8, 8, 2, 2, 1'b1));
		add_row(item_row(32'd9001, 1, 2, 0, 1, 3, 3, 1'b0));
		add_row(item_row(32'd9899, 4, 1, 5, 6, 4, 4, 1'b1));
		add_row(cfg_row('0));
		add_row(item_row(32'd7, 10, 11, 9, 10, 1, 1, 1'b0));
		add_row(item_row(32'd7, 12, 15, 3, 13, 1, 1, 1'b0));
		add_row(item_row(32'd8, 14, 14, 14, 14, 1, 1, 1'b1));
		add_row(cfg_row(20'hFFFFF));
		add_row(item_row(32'h0010_0000, 1, 2, 3, 4, 5, 6, 1'b0));
		add_row(item_row(32'hFFFF_FFFF, 7, 8, 9, 10, 11, 12, 1'b1));
		add_row(cfg_row(20'd604800));
		add_row(item_row(32'd604799, 3, 3, 3, 3, 3, 3, 1'b0));
		add_row(item_row(32'd604800, 4, 4, 4, 4, 4, 4, 1'b1));
		add_row(cfg_row(20'd1));
		add_row(typed_row(item_row('1, 0, '1, 0, '1, 64'h8000_0000_0000_0000,
			32'h8000_0000, 1'b1), 32'hFFFF_FFFF));
		add_row(typed_row(item_row(32'd5, 6, 7, 1, 2, 9, 9, 1'b1), 32'd5));

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				write_interval(plan[i].interval);
			end else begin
				send_candle(plan[i].item);
				if (plan[i].typed) begin
					c = plan[i].item;
					pending_candles[pending_candles.size() - 1] = '{
						candle: '{plan[i].want_bucket, c.open_price, c.high_price,
							c.low_price, c.close_price, c.base_volume, c.quote_volume,
							c.trade_count, c.buy_base_volume, c.sell_base_volume},
						run_last: 1'b1};
				end
			end
		end

		phase_interval = '{20'd900, 20'd1, 20'd0, 20'd60, 20'd604800, 20'hFFFFF,
			ohlc_pkg::len_t'($urandom_range(2, 20'hFFFFF)), 20'd3600};
		foreach (phase_interval[p]) begin
			feed_idle = (p % 3 != 1);
			sink_stall = (p % 3 != 2);
			write_interval(phase_interval[p]);
			run_phase(phase_interval[p], 185);
		end

		// flush whatever is held
		c = rand_candle();
		c.end_of_series = 1'b1;
		send_candle(c);
		drain_pending(200);

		$display("%0d base candles over %0d interval settings, %0d aggregated candles checked",
			items_sent, cfg_writes, results_seen);
		if (mismatches == 0 && pending_candles.size() == 0) begin
			$display("ohlc_candle_aggregator: match");
		end else begin
			$display("%0d field mismatches, %0d candles still pending",
				mismatches, pending_candles.size());
			$display("ohlc_candle_aggregator: mismatch");
		end
		$finish;
	end

	initial begin : watchdog
		#12_000_000;
		$display("timeout with %0d candles pending", pending_candles.size());
		$display("ohlc_candle_aggregator: mismatch");
		$finish;
	end

endmodule
